[rtl/core/svf_mix_pkg.sv]
package svf_mix_pkg;

	// Field and register widths.
	localparam int SAMPLE_W    = 24;
	localparam int STATE_W     = 32;
	localparam int COEFF_FRAC  = 20;
	localparam int COEFF_W     = COEFF_FRAC + 4;
	localparam int MIX_FRAC    = 16;
	localparam int MIX_W       = 18;
	localparam int NUM_REGS    = 8;
	localparam int CFG_IDX_W   = $clog2(NUM_REGS);
	localparam int CFG_DATA_W  = COEFF_W;

	// Datapath widths. The integrator input needs two bits over a state, and the
	// highpass term, the widest multiplier operand, needs six.
	localparam int V3_W   = STATE_W + 2;
	localparam int A_W    = STATE_W + 6;
	localparam int B_W    = COEFF_W + 1;
	localparam int PROD_W = A_W + B_W;
	localparam int ACC_W  = STATE_W + 12;

	localparam logic signed [ACC_W-1:0] STATE_MAX  = ACC_W'((64'sd1 <<< (STATE_W - 1)) - 1);
	localparam logic signed [ACC_W-1:0] STATE_MIN  = -STATE_MAX - 1;
	localparam logic signed [ACC_W-1:0] SAMPLE_MAX = ACC_W'((64'sd1 <<< (SAMPLE_W - 1)) - 1);
	localparam logic signed [ACC_W-1:0] SAMPLE_MIN = -SAMPLE_MAX - 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_G1            = 3'd0,
		REG_G2            = 3'd1,
		REG_G3            = 3'd2,
		REG_DAMPING       = 3'd3,
		REG_LOWPASS_GAIN  = 3'd4,
		REG_HIGHPASS_GAIN = 3'd5,
		REG_BANDPASS_GAIN = 3'd6,
		REG_NOTCH_GAIN    = 3'd7
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_ACC
	} state_t;

	// Product sequence, one pass of the shared multiplier each.
	typedef enum logic [3:0] {
		OP_BAND_G1 = 4'd0,
		OP_BAND_G2 = 4'd1,
		OP_LOW_G3  = 4'd2,
		OP_LOW_G4  = 4'd3,
		OP_DAMP    = 4'd4,
		OP_MIX_LP  = 4'd5,
		OP_MIX_HP  = 4'd6,
		OP_MIX_BP  = 4'd7,
		OP_MIX_BR  = 4'd8
	} op_t;

	typedef enum logic {
		REQ_FILTER = 1'b0,
		REQ_CLEAR  = 1'b1
	} req_t;

	function automatic logic signed [STATE_W-1:0] sat_state(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] c;
		c = v;
		if (v > STATE_MAX) begin
			c = STATE_MAX;
		end else if (v < STATE_MIN) begin
			c = STATE_MIN;
		end
		return c[STATE_W-1:0];
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] sat_sample(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] c;
		c = v;
		if (v > SAMPLE_MAX) begin
			c = SAMPLE_MAX;
		end else if (v < SAMPLE_MIN) begin
			c = SAMPLE_MIN;
		end
		return c[SAMPLE_W-1:0];
	endfunction

endpackage

[rtl/core/state_variable_filter_mix_core.sv]
// Channel  | Direction | Handshake                     | Payload
// ---------+-----------+-------------------------------+---------------------------------
// in       | into core | in_valid / in_stall           | req_type, sample_in
// out      | from core | out_valid / out_stall         | sample_out
// cfg      | into core | cfg_valid / cfg_ready         | cfg_index, cfg_data
//
// The sample and integrator input are latched at the edge that accepts a filter request;
// then nine products pass the shared multiplier, each as a multiply and a round/accumulate
// step. in_stall falls as the result is written, so no new filter request is taken before
// then. A clear request is absorbed in its acceptance cycle and gives no result. Reset
// clears the configuration registers, filter state, sequencer and output valid flag. An
// unclaimed result holds the final step, in_stall high.
module state_variable_filter_mix_core (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	output logic                                    in_stall,
	input  logic                                    req_type,
	input  logic signed [svf_mix_pkg::SAMPLE_W-1:0] sample_in,
	output logic                                    out_valid,
	input  logic                                    out_stall,
	output logic signed [svf_mix_pkg::SAMPLE_W-1:0] sample_out,
	input  logic                                    cfg_valid,
	output logic                                    cfg_ready,
	input  logic [svf_mix_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [svf_mix_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int SW  = svf_mix_pkg::SAMPLE_W;
	localparam int STW = svf_mix_pkg::STATE_W;
	localparam int AW  = svf_mix_pkg::A_W;
	localparam int BW  = svf_mix_pkg::B_W;
	localparam int PW  = svf_mix_pkg::PROD_W;
	localparam int CW  = svf_mix_pkg::ACC_W;
	localparam int VW  = svf_mix_pkg::V3_W;
	localparam int GW  = svf_mix_pkg::COEFF_W;
	localparam int MW  = svf_mix_pkg::MIX_W;

	localparam logic signed [PW-1:0] HALF_COEFF = PW'(64'sd1 <<< (svf_mix_pkg::COEFF_FRAC - 1));
	localparam logic signed [PW-1:0] HALF_MIX   = PW'(64'sd1 <<< (svf_mix_pkg::MIX_FRAC - 1));

	// Configuration registers.
	logic [GW-1:0]        g1_q, g2_q, g3_q, damping_q;
	logic signed [MW-1:0] lp_gain_q, hp_gain_q, bp_gain_q, br_gain_q;

	// Filter state and per-request working registers.
	logic signed [SW-1:0]  prev_q, x_q;
	logic signed [STW-1:0] band_q, low_q, bnew_q;
	logic signed [VW-1:0]  v3_q;
	logic signed [AW-1:0]  br_q, hp_q;
	logic signed [CW-1:0]  acc_q;
	logic signed [PW-1:0]  prod_s1;

	logic signed [SW-1:0]  sample_out_q;
	logic                  out_valid_q;

	svf_mix_pkg::state_t state_q, state_d;
	svf_mix_pkg::op_t    op_q;

	logic                 in_accept;
	logic                 out_free;
	logic                 acc_done;
	logic signed [AW-1:0] mul_a;
	logic signed [BW-1:0] mul_b;
	logic signed [PW-1:0] rnd_coeff, rnd_mix, sh_coeff, sh_mix, neg_adj;
	logic signed [CW-1:0] term;
	logic signed [CW-1:0] br_full;
	logic signed [CW-1:0] hp_full;

	assign cfg_ready  = 1'b1;
	assign in_stall   = (state_q != svf_mix_pkg::ST_IDLE);
	assign in_accept  = in_valid && !in_stall;
	assign out_valid  = out_valid_q;
	assign sample_out = sample_out_q;

	// The output slot can take a new result if it is empty or being drained.
	assign out_free = !out_valid_q || !out_stall;
	assign acc_done = (state_q == svf_mix_pkg::ST_ACC) && (op_q == svf_mix_pkg::OP_MIX_BR)
		&& out_free;

	// Configuration writes. Only the low bits that a register holds are kept.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			g1_q      <= '0;
			g2_q      <= '0;
			g3_q      <= '0;
			damping_q <= '0;
			lp_gain_q <= '0;
			hp_gain_q <= '0;
			bp_gain_q <= '0;
			br_gain_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (svf_mix_pkg::cfg_reg_t'(cfg_index))
				svf_mix_pkg::REG_G1:            g1_q      <= cfg_data[GW-1:0];
				svf_mix_pkg::REG_G2:            g2_q      <= cfg_data[GW-1:0];
				svf_mix_pkg::REG_G3:            g3_q      <= cfg_data[GW-1:0];
				svf_mix_pkg::REG_DAMPING:       damping_q <= cfg_data[GW-1:0];
				svf_mix_pkg::REG_LOWPASS_GAIN:  lp_gain_q <= cfg_data[MW-1:0];
				svf_mix_pkg::REG_HIGHPASS_GAIN: hp_gain_q <= cfg_data[MW-1:0];
				svf_mix_pkg::REG_BANDPASS_GAIN: bp_gain_q <= cfg_data[MW-1:0];
				svf_mix_pkg::REG_NOTCH_GAIN:    br_gain_q <= cfg_data[MW-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer: each product is a multiply step followed by a round and
	// accumulate step. A clear request never leaves idle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= svf_mix_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			svf_mix_pkg::ST_IDLE: begin
				if (in_accept && (req_type == svf_mix_pkg::REQ_FILTER)) begin
					state_d = svf_mix_pkg::ST_MUL;
				end
			end
			svf_mix_pkg::ST_MUL: begin
				state_d = svf_mix_pkg::ST_ACC;
			end
			svf_mix_pkg::ST_ACC: begin
				if (op_q != svf_mix_pkg::OP_MIX_BR) begin
					state_d = svf_mix_pkg::ST_MUL;
				end else if (out_free) begin
					state_d = svf_mix_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = svf_mix_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q <= svf_mix_pkg::OP_BAND_G1;
		end else if (state_q == svf_mix_pkg::ST_IDLE) begin
			op_q <= svf_mix_pkg::OP_BAND_G1;
		end else if ((state_q == svf_mix_pkg::ST_ACC) && (op_q != svf_mix_pkg::OP_MIX_BR)) begin
			op_q <= svf_mix_pkg::op_t'(op_q + 4'd1);
		end
	end

	// Operand selection for the shared multiplier. Coefficients are unsigned
	// and get a zero sign bit; mix gains are sign extended.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (op_q)
			svf_mix_pkg::OP_BAND_G1: begin
				mul_a = AW'(v3_q);
				mul_b = BW'($signed({1'b0, g1_q}));
			end
			svf_mix_pkg::OP_BAND_G2: begin
				mul_a = AW'(band_q);
				mul_b = BW'($signed({1'b0, g2_q}));
			end
			svf_mix_pkg::OP_LOW_G3: begin
				mul_a = AW'(v3_q);
				mul_b = BW'($signed({1'b0, g3_q}));
			end
			svf_mix_pkg::OP_LOW_G4: begin
				// The fourth coefficient is twice g1, folded into the operand.
				mul_a = AW'(band_q) <<< 1;
				mul_b = BW'($signed({1'b0, g1_q}));
			end
			svf_mix_pkg::OP_DAMP: begin
				mul_a = AW'(band_q);
				mul_b = BW'($signed({1'b0, damping_q}));
			end
			svf_mix_pkg::OP_MIX_LP: begin
				mul_a = AW'(low_q);
				mul_b = BW'(lp_gain_q);
			end
			svf_mix_pkg::OP_MIX_HP: begin
				mul_a = hp_q;
				mul_b = BW'(hp_gain_q);
			end
			svf_mix_pkg::OP_MIX_BP: begin
				mul_a = AW'(band_q);
				mul_b = BW'(bp_gain_q);
			end
			svf_mix_pkg::OP_MIX_BR: begin
				mul_a = br_q;
				mul_b = BW'(br_gain_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == svf_mix_pkg::ST_MUL) begin
			prod_s1 <= mul_a * mul_b;
		end
	end

	// Round half away from zero: add one half, less one when the product is
	// negative, then shift arithmetically. With these operand ranges every
	// rounded term stays within the signed 44-bit accumulator range, so no clipping is needed here.
	assign neg_adj   = PW'($signed({1'b0, prod_s1[PW-1]}));
	assign rnd_coeff = prod_s1 + HALF_COEFF - neg_adj;
	assign rnd_mix   = prod_s1 + HALF_MIX - neg_adj;
	assign sh_coeff  = rnd_coeff >>> svf_mix_pkg::COEFF_FRAC;
	assign sh_mix    = rnd_mix >>> svf_mix_pkg::MIX_FRAC;
	assign term      = (op_q >= svf_mix_pkg::OP_MIX_LP) ? sh_mix[CW-1:0] : sh_coeff[CW-1:0];

	// Band-reject and highpass are both formed from the damping product.
	assign br_full = CW'(x_q) - term;
	assign hp_full = br_full - CW'(low_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			band_q <= '0;
			low_q  <= '0;
		end else if (in_accept && (req_type == svf_mix_pkg::REQ_CLEAR)) begin
			prev_q <= '0;
			band_q <= '0;
			low_q  <= '0;
		end else if ((state_q == svf_mix_pkg::ST_ACC) && (op_q == svf_mix_pkg::OP_LOW_G4)) begin
			// Both integrators are committed together once the old band value
			// has been used for the last time.
			prev_q <= x_q;
			band_q <= bnew_q;
			low_q  <= svf_mix_pkg::sat_state(acc_q + term);
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			x_q  <= sample_in;
			v3_q <= VW'(sample_in) + VW'(prev_q) - (VW'(low_q) <<< 1);
		end
		if (state_q == svf_mix_pkg::ST_ACC) begin
			case (op_q)
				svf_mix_pkg::OP_BAND_G1: begin
					acc_q <= CW'(band_q) + term;
				end
				svf_mix_pkg::OP_BAND_G2: begin
					bnew_q <= svf_mix_pkg::sat_state(acc_q - term);
					acc_q  <= CW'(low_q);
				end
				svf_mix_pkg::OP_DAMP: begin
					br_q  <= br_full[AW-1:0];
					hp_q  <= hp_full[AW-1:0];
					acc_q <= '0;
				end
				svf_mix_pkg::OP_LOW_G3, svf_mix_pkg::OP_MIX_LP,
				svf_mix_pkg::OP_MIX_HP, svf_mix_pkg::OP_MIX_BP: begin
					acc_q <= acc_q + term;
				end
				default: ;
			endcase
		end
		if (acc_done) begin
			sample_out_q <= svf_mix_pkg::sat_sample(acc_q + term);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (acc_done) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// A result appears only at the end of the last mix accumulate step.
	a_result_from_sequence: assert property (@(posedge clk) disable iff (!arst_n)
		(!$past(out_valid_q) || !$past(out_stall)) && out_valid_q |->
			$past(state_q == svf_mix_pkg::ST_ACC && op_q == svf_mix_pkg::OP_MIX_BR))
		else $error("result raised outside the final accumulate step");

	// A clear request empties both integrators and does not start a pass.
	a_clear_zeroes: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept && (req_type == svf_mix_pkg::REQ_CLEAR) |=>
			band_q == '0 && low_q == '0 && prev_q == '0 && state_q == svf_mix_pkg::ST_IDLE)
		else $error("clear request did not reset filter state");

	// The previous-input state takes the sample of the pass that commits.
	a_prev_commit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == svf_mix_pkg::ST_ACC && op_q == svf_mix_pkg::OP_LOW_G4 |=>
			prev_q == $past(x_q))
		else $error("previous input not committed with the integrators");

	// The sequencer holds the final step while the output slot is occupied.
	a_hold_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == svf_mix_pkg::ST_ACC && op_q == svf_mix_pkg::OP_MIX_BR && !out_free |=>
			state_q == svf_mix_pkg::ST_ACC && $stable(sample_out_q))
		else $error("final step advanced over an unclaimed result");

endmodule
